[sv/cpl_pkg.sv]
package cpl_pkg;

   localparam int STEPS = 32;
   localparam int NUM_W = 67;
   localparam int DEN_W = 64;
   localparam int MAG_W = 84;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] bz;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
   } lines_type;

   typedef struct packed {
      lines_type               ln;
      logic [DEN_W-1:0]        den;
      logic signed [NUM_W-1:0] ns;
      logic signed [NUM_W-1:0] nt;
   } dots_type;

   typedef struct packed {
      lines_type          ln;
      logic               par;
      logic signed [31:0] s;
      logic signed [31:0] t;
   } params_type;

   typedef struct packed {
      logic signed [31:0] s;
      logic signed [31:0] t;
      logic signed [31:0] pax;
      logic signed [31:0] pay;
      logic signed [31:0] paz;
      logic signed [31:0] pbx;
      logic signed [31:0] pby;
      logic signed [31:0] pbz;
      logic               par;
   } point_type;

   typedef struct packed {
      point_type   pt;
      logic [31:0] sep;
   } result_type;

   function automatic logic [64:0] div_step(logic [63:0] r, logic b, logic [63:0] d);
      logic [65:0] sh;
      logic [65:0] df;
      sh = {1'b0, r, b};
      df = sh - {2'b00, d};
      if (!df[65]) begin
         return {1'b1, df[63:0]};
      end
      return {1'b0, sh[63:0]};
   endfunction

   function automatic logic signed [31:0] sat_quot(logic neg, logic ovf, logic [31:0] q);
      if (neg) begin
         if (ovf || q > 32'h8000_0000) begin
            return 32'sh8000_0000;
         end
         return -$signed(q);
      end
      if (ovf || q[31]) begin
         return 32'sh7FFF_FFFF;
      end
      return $signed(q);
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [40:0] v);
      if (v > 41'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < -41'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic [127:0] sqrt_step(logic [63:0] op, logic [63:0] res,
                                              logic [63:0] one);
      logic [64:0] trial;
      trial = 65'(res) + 65'(one);
      if (65'(op) >= trial) begin
         return {op - trial[63:0], (res >> 1) + one};
      end
      return {op, res >> 1};
   endfunction

endpackage

[sv/cpl_front.sv]
module cpl_front import cpl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  lines_type in_ln,
   output logic      out_valid,
   output dots_type  out_dots
);

   logic [4:0] v_ff;

   lines_type          ln1_ff, ln2_ff, ln3_ff, ln4_ff;
   logic signed [16:0] d1_ff [3];
   logic signed [31:0] pq2_ff [6];
   logic signed [32:0] dq2_ff [6];
   logic signed [32:0] dp2_ff [6];
   logic signed [32:0] n3_ff [3];
   logic signed [33:0] cq3_ff [3];
   logic signed [33:0] cp3_ff [3];
   logic [63:0]        nn4_ff [3];
   logic signed [65:0] cqn4_ff [3];
   logic signed [65:0] cpn4_ff [3];
   dots_type           dots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ln1_ff   <= in_ln;
         d1_ff[0] <= 17'(in_ln.bx) - 17'(in_ln.ax);
         d1_ff[1] <= 17'(in_ln.by) - 17'(in_ln.ay);
         d1_ff[2] <= 17'(in_ln.bz) - 17'(in_ln.az);

         ln2_ff    <= ln1_ff;
         pq2_ff[0] <= 32'(ln1_ff.py) * 32'(ln1_ff.qz);
         pq2_ff[1] <= 32'(ln1_ff.pz) * 32'(ln1_ff.qy);
         pq2_ff[2] <= 32'(ln1_ff.pz) * 32'(ln1_ff.qx);
         pq2_ff[3] <= 32'(ln1_ff.px) * 32'(ln1_ff.qz);
         pq2_ff[4] <= 32'(ln1_ff.px) * 32'(ln1_ff.qy);
         pq2_ff[5] <= 32'(ln1_ff.py) * 32'(ln1_ff.qx);
         dq2_ff[0] <= 33'(d1_ff[1]) * 33'(ln1_ff.qz);
         dq2_ff[1] <= 33'(d1_ff[2]) * 33'(ln1_ff.qy);
         dq2_ff[2] <= 33'(d1_ff[2]) * 33'(ln1_ff.qx);
         dq2_ff[3] <= 33'(d1_ff[0]) * 33'(ln1_ff.qz);
         dq2_ff[4] <= 33'(d1_ff[0]) * 33'(ln1_ff.qy);
         dq2_ff[5] <= 33'(d1_ff[1]) * 33'(ln1_ff.qx);
         dp2_ff[0] <= 33'(d1_ff[1]) * 33'(ln1_ff.pz);
         dp2_ff[1] <= 33'(d1_ff[2]) * 33'(ln1_ff.py);
         dp2_ff[2] <= 33'(d1_ff[2]) * 33'(ln1_ff.px);
         dp2_ff[3] <= 33'(d1_ff[0]) * 33'(ln1_ff.pz);
         dp2_ff[4] <= 33'(d1_ff[0]) * 33'(ln1_ff.py);
         dp2_ff[5] <= 33'(d1_ff[1]) * 33'(ln1_ff.px);

         ln3_ff <= ln2_ff;
         for (int i = 0; i < 3; i++) begin
            n3_ff[i]  <= 33'(pq2_ff[2*i]) - 33'(pq2_ff[2*i+1]);
            cq3_ff[i] <= 34'(dq2_ff[2*i]) - 34'(dq2_ff[2*i+1]);
            cp3_ff[i] <= 34'(dp2_ff[2*i]) - 34'(dp2_ff[2*i+1]);
         end

         ln4_ff <= ln3_ff;
         for (int i = 0; i < 3; i++) begin
            nn4_ff[i]  <= 64'(66'(n3_ff[i]) * 66'(n3_ff[i]));
            cqn4_ff[i] <= 66'(cq3_ff[i]) * 66'(n3_ff[i]);
            cpn4_ff[i] <= 66'(cp3_ff[i]) * 66'(n3_ff[i]);
         end

         dots_ff.ln  <= ln4_ff;
         dots_ff.den <= nn4_ff[0] + nn4_ff[1] + nn4_ff[2];
         dots_ff.ns  <= NUM_W'(cqn4_ff[0]) + NUM_W'(cqn4_ff[1]) + NUM_W'(cqn4_ff[2]);
         dots_ff.nt  <= NUM_W'(cpn4_ff[0]) + NUM_W'(cpn4_ff[1]) + NUM_W'(cpn4_ff[2]);
      end
   end

   assign out_valid = v_ff[4];
   assign out_dots  = dots_ff;

endmodule

[sv/cpl_divider.sv]
module cpl_divider import cpl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  dots_type   in_dots,
   output logic       out_valid,
   output params_type out_par
);

   // two lanes (s, t) share the denominator
   logic             v1_ff, v2_ff;
   lines_type        ln1_ff;
   logic [DEN_W-1:0] den1_ff;
   logic [1:0]       neg1_ff;
   logic [MAG_W-1:0] mag1_ff [2];

   logic [MAG_W-1:0] abs_mag [2];
   logic [NUM_W-1:0] abs_num [2];

   logic             v_ff   [STEPS+1];
   lines_type        ln_ff  [STEPS+1];
   logic [DEN_W-1:0] den_ff [STEPS+1];
   logic [1:0]       neg_ff [STEPS+1];
   logic [1:0]       ovf_ff [STEPS+1];
   logic [63:0]      r_ff   [STEPS+1][2];
   logic [31:0]      low_ff [STEPS+1][2];
   logic [31:0]      q_ff   [STEPS+1][2];

   params_type out_ff;
   logic       vo_ff;

   always_comb begin
      abs_num[0] = in_dots.ns[NUM_W-1] ? NUM_W'(-in_dots.ns) : NUM_W'(in_dots.ns);
      abs_num[1] = in_dots.nt[NUM_W-1] ? NUM_W'(-in_dots.nt) : NUM_W'(in_dots.nt);
      for (int i = 0; i < 2; i++) begin
         abs_mag[i] = MAG_W'({abs_num[i], 16'h0000}) + MAG_W'(in_dots.den >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ln1_ff     <= in_dots.ln;
         den1_ff    <= in_dots.den;
         neg1_ff    <= {in_dots.nt[NUM_W-1], in_dots.ns[NUM_W-1]};
         mag1_ff[0] <= abs_mag[0];
         mag1_ff[1] <= abs_mag[1];

         ln_ff[0]  <= ln1_ff;
         den_ff[0] <= den1_ff;
         neg_ff[0] <= neg1_ff;
         for (int i = 0; i < 2; i++) begin
            ovf_ff[0][i] <= 96'(mag1_ff[i]) >= {den1_ff, 32'h0000_0000};
            r_ff[0][i]   <= 64'(mag1_ff[i][MAG_W-1:32]);
            low_ff[0][i] <= mag1_ff[i][31:0];
            q_ff[0][i]   <= '0;
         end
      end
   end

   assign v_ff[0] = v2_ff;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [64:0] step [2];

      always_comb begin
         for (int i = 0; i < 2; i++) begin
            step[i] = div_step(r_ff[k][i], low_ff[k][i][31], den_ff[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ln_ff[k+1]  <= ln_ff[k];
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            for (int i = 0; i < 2; i++) begin
               r_ff[k+1][i]   <= step[i][63:0];
               low_ff[k+1][i] <= {low_ff[k][i][30:0], 1'b0};
               q_ff[k+1][i]   <= {q_ff[k][i][30:0], step[i][64]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.ln  <= ln_ff[STEPS];
         out_ff.par <= den_ff[STEPS] == '0;
         if (den_ff[STEPS] == '0) begin
            out_ff.s <= '0;
            out_ff.t <= '0;
         end else begin
            out_ff.s <= sat_quot(neg_ff[STEPS][0], ovf_ff[STEPS][0], q_ff[STEPS][0]);
            out_ff.t <= sat_quot(neg_ff[STEPS][1], ovf_ff[STEPS][1], q_ff[STEPS][1]);
         end
      end
   end

   assign out_valid = vo_ff;
   assign out_par   = out_ff;

endmodule

[sv/cpl_points.sv]
module cpl_points import cpl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  params_type  in_par,
   output logic        out_valid,
   output point_type   out_pt,
   output logic [63:0] out_sq,
   output logic        out_big
);

   logic [4:0] v_ff;

   params_type         par1_ff;
   logic signed [47:0] pr1_ff [6];
   point_type          pt2_ff, pt3_ff, pt4_ff, pt5_ff;
   logic [32:0]        ab3_ff [3];
   logic [65:0]        sq4_ff [3];
   logic [63:0]        sq5_ff;
   logic               big5_ff;

   logic signed [40:0] sum2 [6];
   logic signed [15:0] org1 [6];
   logic signed [31:0] pa2 [3];
   logic signed [31:0] pb2 [3];
   logic signed [32:0] dif3 [3];
   logic [66:0]        tot4;

   always_comb begin
      org1[0] = par1_ff.ln.ax;
      org1[1] = par1_ff.ln.ay;
      org1[2] = par1_ff.ln.az;
      org1[3] = par1_ff.ln.bx;
      org1[4] = par1_ff.ln.by;
      org1[5] = par1_ff.ln.bz;
      for (int i = 0; i < 6; i++) begin
         sum2[i] = 41'($signed({org1[i], 8'h00})) + 41'((pr1_ff[i] + 48'sd128) >>> 8);
      end
      pa2[0] = pt2_ff.pax;
      pa2[1] = pt2_ff.pay;
      pa2[2] = pt2_ff.paz;
      pb2[0] = pt2_ff.pbx;
      pb2[1] = pt2_ff.pby;
      pb2[2] = pt2_ff.pbz;
      for (int i = 0; i < 3; i++) begin
         dif3[i] = 33'(pa2[i]) - 33'(pb2[i]);
      end
      tot4 = 67'(sq4_ff[0]) + 67'(sq4_ff[1]) + 67'(sq4_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         par1_ff   <= in_par;
         pr1_ff[0] <= 48'(in_par.s) * 48'(in_par.ln.px);
         pr1_ff[1] <= 48'(in_par.s) * 48'(in_par.ln.py);
         pr1_ff[2] <= 48'(in_par.s) * 48'(in_par.ln.pz);
         pr1_ff[3] <= 48'(in_par.t) * 48'(in_par.ln.qx);
         pr1_ff[4] <= 48'(in_par.t) * 48'(in_par.ln.qy);
         pr1_ff[5] <= 48'(in_par.t) * 48'(in_par.ln.qz);

         pt2_ff.s   <= par1_ff.s;
         pt2_ff.t   <= par1_ff.t;
         pt2_ff.par <= par1_ff.par;
         pt2_ff.pax <= sat32(sum2[0]);
         pt2_ff.pay <= sat32(sum2[1]);
         pt2_ff.paz <= sat32(sum2[2]);
         pt2_ff.pbx <= sat32(sum2[3]);
         pt2_ff.pby <= sat32(sum2[4]);
         pt2_ff.pbz <= sat32(sum2[5]);

         pt3_ff <= pt2_ff;
         for (int i = 0; i < 3; i++) begin
            ab3_ff[i] <= dif3[i][32] ? 33'(-dif3[i]) : 33'(dif3[i]);
         end

         pt4_ff <= pt3_ff;
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= 66'(ab3_ff[i]) * 66'(ab3_ff[i]);
         end

         pt5_ff  <= pt4_ff;
         sq5_ff  <= tot4[63:0];
         big5_ff <= |tot4[66:64];
      end
   end

   assign out_valid = v_ff[4];
   assign out_pt    = pt5_ff;
   assign out_sq    = sq5_ff;
   assign out_big   = big5_ff;

endmodule

[sv/cpl_sqrt.sv]
module cpl_sqrt import cpl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  point_type   in_pt,
   input  logic [63:0] in_sq,
   input  logic        in_big,
   output logic        out_valid,
   output result_type  out_res
);

   logic        v_ff   [STEPS+1];
   point_type   pt_ff  [STEPS+1];
   logic        big_ff [STEPS+1];
   logic [63:0] op_ff  [STEPS+1];
   logic [63:0] res_ff [STEPS+1];

   logic        vo_ff;
   result_type  res_out_ff;
   logic [63:0] rnd;

   assign v_ff[0]   = in_valid;
   assign pt_ff[0]  = in_pt;
   assign big_ff[0] = in_big;
   assign op_ff[0]  = in_sq;
   assign res_ff[0] = '0;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [63:0] One = 64'd1 << (62 - 2 * k);
      logic [127:0] step;

      assign step = sqrt_step(op_ff[k], res_ff[k], One);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pt_ff[k+1]  <= pt_ff[k];
            big_ff[k+1] <= big_ff[k];
            op_ff[k+1]  <= step[127:64];
            res_ff[k+1] <= step[63:0];
         end
      end
   end

   assign rnd = (op_ff[STEPS] > res_ff[STEPS]) ? res_ff[STEPS] + 64'd1 : res_ff[STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_out_ff.pt  <= pt_ff[STEPS];
         res_out_ff.sep <= (big_ff[STEPS] || |rnd[63:32]) ? 32'hFFFF_FFFF : rnd[31:0];
      end
   end

   assign out_valid = vo_ff;
   assign out_res   = res_out_ff;

endmodule

[sv/closest_points_two_lines_3d.sv]
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  two lines: origins and directions, Q8.8
// rsp_      out        rsp_valid/rsp_stall  s, t, both points, separation, parallel flag
//
// one request per cycle while req_stall is low; the pipeline runs through the dot
// products, the two quotient lanes at one bit per stage, the points and the root
// reset clears only the valid bits of every stage
// a held result freezes the whole pipeline; req_stall follows it in the same cycle
module closest_points_two_lines_3d import cpl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_origin_a_x,
   input  logic signed [15:0] req_origin_a_y,
   input  logic signed [15:0] req_origin_a_z,
   input  logic signed [15:0] req_dir_a_x,
   input  logic signed [15:0] req_dir_a_y,
   input  logic signed [15:0] req_dir_a_z,
   input  logic signed [15:0] req_origin_b_x,
   input  logic signed [15:0] req_origin_b_y,
   input  logic signed [15:0] req_origin_b_z,
   input  logic signed [15:0] req_dir_b_x,
   input  logic signed [15:0] req_dir_b_y,
   input  logic signed [15:0] req_dir_b_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_param_s,
   output logic signed [31:0] rsp_param_t,
   output logic signed [31:0] rsp_near_a_x,
   output logic signed [31:0] rsp_near_a_y,
   output logic signed [31:0] rsp_near_a_z,
   output logic signed [31:0] rsp_near_b_x,
   output logic signed [31:0] rsp_near_b_y,
   output logic signed [31:0] rsp_near_b_z,
   output logic        [31:0] rsp_separation,
   output logic               rsp_parallel_flag
);

   logic        en;
   lines_type   ln;
   logic        dots_valid, par_valid, pt_valid;
   dots_type    dots;
   params_type  params;
   point_type   pt;
   logic [63:0] sq;
   logic        big;
   result_type  res;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   assign ln = '{ax: req_origin_a_x, ay: req_origin_a_y, az: req_origin_a_z,
                 px: req_dir_a_x,    py: req_dir_a_y,    pz: req_dir_a_z,
                 bx: req_origin_b_x, by: req_origin_b_y, bz: req_origin_b_z,
                 qx: req_dir_b_x,    qy: req_dir_b_y,    qz: req_dir_b_z};

   cpl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_ln     (ln),
      .out_valid (dots_valid),
      .out_dots  (dots)
   );

   cpl_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dots_valid),
      .in_dots   (dots),
      .out_valid (par_valid),
      .out_par   (params)
   );

   cpl_points u_points (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (par_valid),
      .in_par    (params),
      .out_valid (pt_valid),
      .out_pt    (pt),
      .out_sq    (sq),
      .out_big   (big)
   );

   cpl_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pt_valid),
      .in_pt     (pt),
      .in_sq     (sq),
      .in_big    (big),
      .out_valid (rsp_valid),
      .out_res   (res)
   );

   assign rsp_param_s       = res.pt.s;
   assign rsp_param_t       = res.pt.t;
   assign rsp_near_a_x      = res.pt.pax;
   assign rsp_near_a_y      = res.pt.pay;
   assign rsp_near_a_z      = res.pt.paz;
   assign rsp_near_b_x      = res.pt.pbx;
   assign rsp_near_b_y      = res.pt.pby;
   assign rsp_near_b_z      = res.pt.pbz;
   assign rsp_separation    = res.sep;
   assign rsp_parallel_flag = res.pt.par;

endmodule

[sv/cpl_checker.sv]
module cpl_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_param_s,
   input logic signed [31:0] rsp_param_t,
   input logic        [31:0] rsp_separation,
   input logic               rsp_parallel_flag
);

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parallel_flag |-> rsp_param_s == 0 && rsp_param_t == 0)
      else $error("parallel response with nonzero parameters");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_separation)
                                 && $stable(rsp_param_s))
      else $error("held response changed");

endmodule

bind closest_points_two_lines_3d cpl_checker u_cpl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_param_s       (rsp_param_s),
   .rsp_param_t       (rsp_param_t),
   .rsp_separation    (rsp_separation),
   .rsp_parallel_flag (rsp_parallel_flag)
);

[dv/tb_top.sv]
module tb_top;
   import cpl_pkg::*;

   typedef struct {
      logic signed [31:0] s;
      logic signed [31:0] t;
      logic signed [31:0] na [3];
      logic signed [31:0] nb [3];
      logic [31:0]        sep;
      logic               par;
   } line_fit_type;

   typedef struct {
      lines_type    ln;
      bit           typed;
      line_fit_type fit;
   } line_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_origin_a_x, req_origin_a_y, req_origin_a_z;
   logic signed [15:0] req_dir_a_x, req_dir_a_y, req_dir_a_z;
   logic signed [15:0] req_origin_b_x, req_origin_b_y, req_origin_b_z;
   logic signed [15:0] req_dir_b_x, req_dir_b_y, req_dir_b_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_param_s, rsp_param_t;
   logic signed [31:0] rsp_near_a_x, rsp_near_a_y, rsp_near_a_z;
   logic signed [31:0] rsp_near_b_x, rsp_near_b_y, rsp_near_b_z;
   logic        [31:0] rsp_separation;
   logic               rsp_parallel_flag;

   line_fit_type fit_queue[$];
   int        failures = 0;
   int        sent_count = 0;
   int        checked_count = 0;
   int        parallel_count = 0;
   int        saturated_count = 0;
   int        send_idle_pct = 8;
   int        recv_idle_pct = 61;
   logic      hold_off = 1'b0;

   closest_points_two_lines_3d i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("closest_points_two_lines_3d verification failed");
      $finish;
   end

   function automatic logic signed [127:0] rounded_ratio(logic signed [127:0] num,
                                                         logic [127:0] den);
      logic        neg;
      logic [127:0] mag;
      logic [127:0] quo;
      logic [127:0] limit;
      neg = num < 0;
      mag = neg ? -num : num;
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      quo = ((mag << 16) + (den >> 1)) / den;
      if (quo > limit) begin
         return neg ? -128'sd2147483648 : 128'sd2147483647;
      end
      return neg ? -$signed(quo) : $signed(quo);
   endfunction

   function automatic logic signed [31:0] clip32(logic signed [127:0] v);
      if (v > 128'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < -128'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic line_fit_type closest_fit(lines_type ln);
      line_fit_type         f;
      logic signed [127:0]  a [3], p [3], b [3], q [3], d [3];
      logic signed [127:0]  n [3], cq [3], cp [3];
      logic signed [127:0]  ns, nt, den, s, t, diff, pa, pb;
      logic [127:0]         sq, root, trial;
      a = '{ln.ax, ln.ay, ln.az};
      p = '{ln.px, ln.py, ln.pz};
      b = '{ln.bx, ln.by, ln.bz};
      q = '{ln.qx, ln.qy, ln.qz};
      for (int i = 0; i < 3; i++) d[i] = b[i] - a[i];
      for (int i = 0; i < 3; i++) begin
         n[i]  = p[(i+1)%3] * q[(i+2)%3] - p[(i+2)%3] * q[(i+1)%3];
         cq[i] = d[(i+1)%3] * q[(i+2)%3] - d[(i+2)%3] * q[(i+1)%3];
         cp[i] = d[(i+1)%3] * p[(i+2)%3] - d[(i+2)%3] * p[(i+1)%3];
      end
      den = 0; ns = 0; nt = 0;
      for (int i = 0; i < 3; i++) begin
         den += n[i] * n[i];
         ns  += cq[i] * n[i];
         nt  += cp[i] * n[i];
      end
      s = 0; t = 0;
      if (den != 0) begin
         s = rounded_ratio(ns, den);
         t = rounded_ratio(nt, den);
      end
      f.s = s[31:0];
      f.t = t[31:0];
      f.par = den == 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         pa = a[i] * 256 + ((s * p[i] + 128) >>> 8);
         pb = b[i] * 256 + ((t * q[i] + 128) >>> 8);
         f.na[i] = clip32(pa);
         f.nb[i] = clip32(pb);
         diff = 128'(f.na[i]) - 128'(f.nb[i]);
         sq += diff * diff;
      end
      root = 0;
      for (int k = 32; k >= 0; k--) begin
         trial = root | (128'd1 << k);
         if (trial * trial <= sq) root = trial;
      end
      if (sq - root * root > root) root++;
      f.sep = root > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : root[31:0];
      return f;
   endfunction

   function automatic line_fit_type fit_of(logic signed [31:0] s, logic signed [31:0] t,
                                           logic signed [31:0] ax, logic signed [31:0] bz,
                                           logic [31:0] sep, logic par);
      line_fit_type f;
      f.s = s; f.t = t;
      f.na = '{ax, 0, 0};
      f.nb = '{0, 0, bz};
      f.sep = sep; f.par = par;
      return f;
   endfunction

   function automatic lines_type random_lines();
      lines_type ln;
      int        kind;
      int        k;
      ln = lines_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      kind = $urandom_range(99);
      if (kind < 10) begin
         k = $urandom_range(4) - 2;
         ln.qx = 16'(ln.px * k); ln.qy = 16'(ln.py * k); ln.qz = 16'(ln.pz * k);
      end else if (kind < 18) begin
         ln.qx = ln.px + $signed(16'($urandom_range(2))) - 16'sd1;
         ln.qy = ln.py; ln.qz = ln.pz;
      end else if (kind < 35) begin
         ln.px = $signed(16'($urandom_range(2047))) - 16'sd1024;
         ln.py = $signed(16'($urandom_range(2047))) - 16'sd1024;
         ln.pz = $signed(16'($urandom_range(2047))) - 16'sd1024;
         ln.qx = $signed(16'($urandom_range(2047))) - 16'sd1024;
         ln.qy = $signed(16'($urandom_range(2047))) - 16'sd1024;
         ln.qz = $signed(16'($urandom_range(2047))) - 16'sd1024;
      end else if (kind < 40) begin
         if ($urandom_range(1)) {ln.px, ln.py, ln.pz} = '0;
         else {ln.qx, ln.qy, ln.qz} = '0;
      end
      return ln;
   endfunction

   task automatic offer(lines_type ln);
      req_valid <= 1'b1;
      {req_origin_a_x, req_origin_a_y, req_origin_a_z} <= {ln.ax, ln.ay, ln.az};
      {req_dir_a_x, req_dir_a_y, req_dir_a_z}          <= {ln.px, ln.py, ln.pz};
      {req_origin_b_x, req_origin_b_y, req_origin_b_z} <= {ln.bx, ln.by, ln.bz};
      {req_dir_b_x, req_dir_b_y, req_dir_b_z}          <= {ln.qx, ln.qy, ln.qz};
      do @(posedge clock); while (req_stall);
      sent_count++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_row(line_row_type row);
      line_fit_type f;
      f = row.typed ? row.fit : closest_fit(row.ln);
      offer(row.ln);
      fit_queue.push_back(f);
      if (f.par) parallel_count++;
      if (f.s == 32'sh7FFF_FFFF || f.s == 32'sh8000_0000) saturated_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : (hold_off || $urandom_range(99) < recv_idle_pct);
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      line_fit_type f;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fit_queue.size() == 0) begin
            $error("result with no request pending");
            failures++;
         end else begin
            f = fit_queue.pop_front();
            checked_count++;
            check_field("param_s", f.s, rsp_param_s);
            check_field("param_t", f.t, rsp_param_t);
            check_field("near_a_x", f.na[0], rsp_near_a_x);
            check_field("near_a_y", f.na[1], rsp_near_a_y);
            check_field("near_a_z", f.na[2], rsp_near_a_z);
            check_field("near_b_x", f.nb[0], rsp_near_b_x);
            check_field("near_b_y", f.nb[1], rsp_near_b_y);
            check_field("near_b_z", f.nb[2], rsp_near_b_z);
            check_field("separation", f.sep, rsp_separation);
            check_field("parallel_flag", 32'(f.par), 32'(rsp_parallel_flag));
         end
      end
   end

   initial begin
      line_row_type rows[$];
      line_row_type r;
      int           waited;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_origin_a_x, req_origin_a_y, req_origin_a_z} = '0;
      {req_dir_a_x, req_dir_a_y, req_dir_a_z} = '0;
      {req_origin_b_x, req_origin_b_y, req_origin_b_z} = '0;
      {req_dir_b_x, req_dir_b_y, req_dir_b_z} = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      r.typed = 1; r.ln = '0;
      r.fit = fit_of(0, 0, 0, 0, 0, 1);
      rows.push_back(r);
      r.ln.ax = 256;
      r.fit = fit_of(0, 0, 65536, 0, 65536, 1);
      rows.push_back(r);
      r.ln = '0; r.ln.px = 256; r.ln.bz = 256; r.ln.qy = 256;
      r.fit = fit_of(0, 0, 0, 65536, 65536, 0);
      rows.push_back(r);
      r.typed = 0;
      r.ln = {12{16'sh8000}}; rows.push_back(r);
      r.ln = {12{16'sh7FFF}}; rows.push_back(r);
      r.ln = {{6{16'sh8000}}, {6{16'sh7FFF}}}; rows.push_back(r);
      r.ln = {{3{16'sh7FFF}}, 16'sh7FFF, 16'sh0, 16'sh0, {3{16'sh8000}},
              16'sh0, 16'sh8000, 16'sh0};
      rows.push_back(r);
      r.ln = {48'h0, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
              16'sh0100, 16'sh0100, 16'sh0101};
      rows.push_back(r);
      r.ln = {{3{16'sh7FFF}}, 16'sh0001, 16'sh0, 16'sh0, {3{16'sh8000}},
              16'sh0001, 16'sh0001, 16'sh0};
      rows.push_back(r);
      r.ln = {{3{16'sh0}}, 16'sh8000, 16'sh8000, 16'sh8000, {3{16'sh10}},
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      rows.push_back(r);
      r.ln = {16'sh1234, 16'shF00D, 16'sh0, 16'sh0200, 16'sh0300, 16'shFF00,
              16'sh0, 16'sh0, 16'sh0, {3{16'sh0}}};
      rows.push_back(r);
      r.ln = {{3{16'sh8000}}, 16'sh0300, 16'sh0100, 16'shFF80, {3{16'sh7FFF}},
              16'shFD00, 16'shFF00, 16'sh0080};
      rows.push_back(r);
      foreach (rows[i]) send_row(rows[i]);

      for (int i = 0; i < 1950; i++) begin
         if (i == 650) begin
            send_idle_pct = 61; recv_idle_pct = 8;
         end
         if (i == 1300) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         r.typed = 0;
         r.ln = random_lines();
         send_row(r);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (fit_queue.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (fit_queue.size() != 0) begin
         $error("%0d results never arrived", fit_queue.size());
         failures++;
      end
      $display("%0d requests sent, %0d results checked", sent_count, checked_count);
      $display("%0d parallel cases, %0d saturated s values", parallel_count,
               saturated_count);
      if (failures == 0) begin
         $display("closest_points_two_lines_3d verification clean");
      end else begin
         $display("closest_points_two_lines_3d verification failed");
      end
      $finish;
   end

   initial begin
      int held;
      wait (sent_count >= 1412);
      hold_off <= 1'b1;
      held = 0;
      while (held < 400) begin
         @(posedge clock);
         held++;
      end
      hold_off <= 1'b0;
   end

endmodule
